>>> src/swpf_pkg.sv
// ----------------------------------------------------------------------------
// swpf_pkg
// Shared widths, codes and reset values of the shallow-water flux pipeline.
// ----------------------------------------------------------------------------
package swpf_pkg;

  localparam int VW    = 32;  // value width, Q16.16
  localparam int NW    = 16;  // normal width, Q2.14
  localparam int NFRAC = 14;  // normal fraction bits
  localparam int GW    = 24;  // gravity width, Q8.16
  localparam int MHW   = 31;  // min height width
  localparam int DIMW  = 2;
  localparam int CFGW  = 31;  // widest register
  localparam int NITER = 32;  // radix-2 divide / square-root steps

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [NW-1:0] nrm_t;

  typedef enum logic [1:0] {
    CMD_FLUX  = 2'd0,
    CMD_SPEED = 2'd1,
    CMD_GHOST = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BND_LAND      = 2'd0,
    BND_RADIATION = 2'd1,
    BND_RIVER     = 2'd2,
    BND_SEA       = 2'd3
  } bnd_t;

  typedef enum logic [1:0] {
    CFG_GRAVITY    = 2'd0,
    CFG_DIMENSION  = 2'd1,
    CFG_MIN_HEIGHT = 2'd2,
    CFG_SPARE      = 2'd3
  } cfg_idx_t;

  localparam logic [DIMW-1:0] DIM_ONE        = 2'd1;
  localparam logic [DIMW-1:0] DIM_RST        = 2'd2;
  localparam logic [GW-1:0]   GRAVITY_RST    = 24'd642908;
  localparam logic [MHW-1:0]  MIN_HEIGHT_RST = 31'd1;

endpackage

>>> src/swpf_in_if.sv
// ----------------------------------------------------------------------------
// swpf_in_if
// Input item channel: inner state, normal, boundary kind and outer state.
// ----------------------------------------------------------------------------
interface swpf_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  swpf_pkg::val_t       height;
  swpf_pkg::val_t       momentum_x;
  swpf_pkg::val_t       momentum_y;
  swpf_pkg::nrm_t       normal_x;
  swpf_pkg::nrm_t       normal_y;
  logic [1:0]           boundary_kind;
  swpf_pkg::val_t       outer_height;
  swpf_pkg::val_t       outer_momentum_x;
  swpf_pkg::val_t       outer_momentum_y;

  modport source (
    output valid, cmd, height, momentum_x, momentum_y, normal_x, normal_y,
           boundary_kind, outer_height, outer_momentum_x, outer_momentum_y,
    input  ready
  );
  modport sink (
    input  valid, cmd, height, momentum_x, momentum_y, normal_x, normal_y,
           boundary_kind, outer_height, outer_momentum_x, outer_momentum_y,
    output ready
  );
endinterface

>>> src/swpf_out_if.sv
// ----------------------------------------------------------------------------
// swpf_out_if
// Result channel: flux matrix, wave speed, ghost state and height flag.
// ----------------------------------------------------------------------------
interface swpf_out_if;
  logic                       valid;
  logic                       ready;
  swpf_pkg::val_t             mass_flux_x;
  swpf_pkg::val_t             mass_flux_y;
  swpf_pkg::val_t             xmom_flux_x;
  swpf_pkg::val_t             xmom_flux_y;
  swpf_pkg::val_t             ymom_flux_x;
  swpf_pkg::val_t             ymom_flux_y;
  logic [swpf_pkg::VW-2:0]    wave_speed;
  swpf_pkg::val_t             ghost_height;
  swpf_pkg::val_t             ghost_momentum_x;
  swpf_pkg::val_t             ghost_momentum_y;
  logic                       height_too_small;

  modport source (
    output valid, mass_flux_x, mass_flux_y, xmom_flux_x, xmom_flux_y, ymom_flux_x,
           ymom_flux_y, wave_speed, ghost_height, ghost_momentum_x, ghost_momentum_y,
           height_too_small,
    input  ready
  );
  modport sink (
    input  valid, mass_flux_x, mass_flux_y, xmom_flux_x, xmom_flux_y, ymom_flux_x,
           ymom_flux_y, wave_speed, ghost_height, ghost_momentum_x, ghost_momentum_y,
           height_too_small,
    output ready
  );
endinterface

>>> src/shallow_water_pointwise_flux.sv
// ----------------------------------------------------------------------------
// shallow_water_pointwise_flux
// Pipelined shallow-water flux, wave speed and boundary ghost state evaluator.
// ----------------------------------------------------------------------------
// One item enters per cycle when the output is not stalled. The pipeline
// holds 7 front stages (magnitudes, products, dot product, gravity term,
// reflected momentum), 32 stages of four radix-2 dividers and one radix-2
// square-root unit that each retire one quotient or root bit per stage, and
// the output register. Every stage holds its own valid bit, so bubbles close
// up and a stalled output holds while the stages in front of it keep filling.
module shallow_water_pointwise_flux (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_idx,
  input  logic [swpf_pkg::CFGW-1:0] cfg_wdata,
  swpf_in_if.sink                  in_ch,
  swpf_out_if.source               out_ch
);

  localparam int NITER = swpf_pkg::NITER;
  localparam int NST   = 7 + NITER + 1;
  localparam int LAST  = NST - 1;
  localparam int DXX = 0, DXY = 1, DYY = 2, DSP = 3;

  typedef struct packed {
    logic [1:0]     cmd;
    swpf_pkg::val_t h, mx, my;
    swpf_pkg::nrm_t nx, ny;
    logic [1:0]     kind;
    swpf_pkg::val_t oh, omx, omy;
  } a_t;

  typedef struct packed {
    logic [1:0]     cmd;
    logic           two, bad, xyn, land2;
    logic [30:0]    hm;
    logic [31:0]    mxm, mym;
    swpf_pkg::val_t mx, my;
    swpf_pkg::nrm_t nx, ny;
    swpf_pkg::val_t gh, gx, gy;
  } b_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                two, bad, xyn, land2;
    logic [30:0]         hm;
    swpf_pkg::val_t      mx, my;
    swpf_pkg::nrm_t      nx, ny;
    swpf_pkg::val_t      gh, gx, gy;
    logic [63:0]         pxx, pxy, pyy;
    logic signed [47:0]  pxn, pyn;
    logic [54:0]         pgh;
    logic [61:0]         phh;
  } c_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                two, bad, xyn, land2;
    logic [30:0]         hm;
    swpf_pkg::val_t      mx, my;
    swpf_pkg::nrm_t      nx, ny;
    swpf_pkg::val_t      gh, gx, gy;
    logic [63:0]         pxx, pxy, pyy;
    logic [54:0]         pgh;
    logic signed [48:0]  dot;
    logic [54:0]         hgh, hgl;
  } d_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                two, bad, xyn, land2;
    logic [30:0]         hm;
    swpf_pkg::val_t      mx, my;
    swpf_pkg::val_t      gh, gx, gy;
    logic [63:0]         pxx, pxy, pyy;
    logic [54:0]         pgh;
    logic [47:0]         dotm;
    logic [30:0]         half;
    logic signed [64:0]  dnx, dny;
  } e_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                two, bad, xyn, land2;
    logic [30:0]         hm;
    swpf_pkg::val_t      mx, my;
    swpf_pkg::val_t      gh, gx, gy;
    logic [63:0]         pxx, pxy, pyy;
    logic [54:0]         pgh;
    logic [47:0]         dotm;
    logic [30:0]         half;
    logic signed [66:0]  vx, vy;
  } f_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                two, bad, xyn;
    logic [30:0]         hm;
    swpf_pkg::val_t      mx, my;
    swpf_pkg::val_t      gh, gx, gy;
    logic [63:0]         pxx, pxy, pyy;
    logic [54:0]         pgh;
    logic [47:0]         dotm;
    logic [30:0]         half;
  } g_t;

  typedef struct packed {
    logic        ovf;
    logic [30:0] rem;
    logic [31:0] dq;
  } div_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic            two, bad, xyn;
    logic [30:0]     hm;
    swpf_pkg::val_t  mx, my;
    swpf_pkg::val_t  gh, gx, gy;
    logic [30:0]     half;
    div_t [3:0]      div;
    sq_t             sq;
  } it_t;

  typedef struct packed {
    swpf_pkg::val_t  mass_x, mass_y, xmom_x, xmom_y, ymom_x, ymom_y;
    logic [30:0]     speed;
    swpf_pkg::val_t  gh, gx, gy;
    logic            small_h;
  } out_t;

  function automatic swpf_pkg::val_t pack_sm(input logic neg, input logic [38:0] mag);
    logic [38:0] lim;
    logic [38:0] m;
    logic [38:0] r;
    lim = neg ? 39'h80000000 : 39'h7fffffff;
    m   = (mag > lim) ? lim : mag;
    r   = neg ? -m : m;
    return r[31:0];
  endfunction

  function automatic div_t div_init(input logic [63:0] dvd, input logic [30:0] hm);
    div_t r;
    r.ovf = dvd[63:32] >= {1'b0, hm};
    r.rem = dvd[62:32];
    r.dq  = dvd[31:0];
    return r;
  endfunction

  function automatic div_t div_step(input div_t d, input logic [30:0] hm);
    div_t        r;
    logic [31:0] acc;
    acc   = {d.rem, d.dq[31]};
    r.ovf = d.ovf;
    if (acc >= {1'b0, hm}) begin
      r.rem = 31'(acc - {1'b0, hm});
      r.dq  = {d.dq[30:0], 1'b1};
    end else begin
      r.rem = acc[30:0];
      r.dq  = {d.dq[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t         r;
    logic [35:0] acc;
    logic [35:0] trial;
    acc   = {s.rem, s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = 34'(acc - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = acc[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] flux_cap(input div_t d);
    return (d.ovf || d.dq > 32'h80000000) ? 32'h80000000 : d.dq;
  endfunction

  // configuration registers
  logic [swpf_pkg::GW-1:0]   gravity_r;
  logic [swpf_pkg::DIMW-1:0] dimension_r;
  logic [swpf_pkg::MHW-1:0]  min_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r    <= swpf_pkg::GRAVITY_RST;
      dimension_r  <= swpf_pkg::DIM_RST;
      min_height_r <= swpf_pkg::MIN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (swpf_pkg::cfg_idx_t'(cfg_idx))
        swpf_pkg::CFG_GRAVITY:    gravity_r    <= cfg_wdata[swpf_pkg::GW-1:0];
        swpf_pkg::CFG_DIMENSION:  dimension_r  <= cfg_wdata[swpf_pkg::DIMW-1:0];
        swpf_pkg::CFG_MIN_HEIGHT: min_height_r <= cfg_wdata[swpf_pkg::MHW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NST-1:0] vld_r, vld_nxt, vld_prev;
  logic [NST:0]   adv;

  assign adv[NST] = out_ch.ready;
  generate
    for (genvar k = 0; k < NST; k++) begin : g_adv
      assign adv[k] = ~vld_r[k] | adv[k+1];
    end
  endgenerate

  assign vld_prev     = {vld_r[NST-2:0], in_ch.valid};
  assign vld_nxt      = (adv[NST-1:0] & vld_prev) | (~adv[NST-1:0] & vld_r);
  assign in_ch.ready  = adv[0];
  assign out_ch.valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage a: input register
  a_t a_r, a_nxt;
  always_comb begin
    a_nxt.cmd  = in_ch.cmd;
    a_nxt.h    = in_ch.height;
    a_nxt.mx   = in_ch.momentum_x;
    a_nxt.my   = in_ch.momentum_y;
    a_nxt.nx   = in_ch.normal_x;
    a_nxt.ny   = in_ch.normal_y;
    a_nxt.kind = in_ch.boundary_kind;
    a_nxt.oh   = in_ch.outer_height;
    a_nxt.omx  = in_ch.outer_momentum_x;
    a_nxt.omy  = in_ch.outer_momentum_y;
  end
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_r <= a_nxt;
    end
  end

  // stage b: magnitudes, height check, simple ghost cases
  b_t b_r, b_nxt;
  always_comb begin
    b_nxt.cmd = a_r.cmd;
    b_nxt.two = dimension_r != swpf_pkg::DIM_ONE;
    b_nxt.my  = b_nxt.two ? a_r.my : '0;
    b_nxt.ny  = b_nxt.two ? a_r.ny : '0;
    b_nxt.mx  = a_r.mx;
    b_nxt.nx  = a_r.nx;
    b_nxt.hm  = a_r.h[30:0];
    b_nxt.bad = a_r.h[31] || (a_r.h[30:0] == '0) || (a_r.h[30:0] < min_height_r);
    b_nxt.mxm = a_r.mx[31] ? 32'(-a_r.mx) : 32'(a_r.mx);
    b_nxt.mym = b_nxt.my[31] ? 32'(-b_nxt.my) : 32'(b_nxt.my);
    b_nxt.xyn = (a_r.mx[31] ^ b_nxt.my[31]);
    b_nxt.land2 = 1'b0;
    case (swpf_pkg::bnd_t'(a_r.kind))
      swpf_pkg::BND_LAND: begin
        b_nxt.land2 = b_nxt.two;
        b_nxt.gh    = a_r.h;
        b_nxt.gx    = pack_sm(~a_r.mx[31], 39'(b_nxt.mxm));
        b_nxt.gy    = b_nxt.my;
      end
      swpf_pkg::BND_RADIATION: begin
        b_nxt.gh = a_r.h;
        b_nxt.gx = a_r.mx;
        b_nxt.gy = b_nxt.my;
      end
      swpf_pkg::BND_RIVER: begin
        b_nxt.gh = a_r.oh;
        b_nxt.gx = a_r.omx;
        b_nxt.gy = b_nxt.two ? a_r.omy : '0;
      end
      swpf_pkg::BND_SEA: begin
        b_nxt.gh = a_r.oh;
        b_nxt.gx = a_r.mx;
        b_nxt.gy = b_nxt.my;
      end
      default: begin
        b_nxt.gh = '0;
        b_nxt.gx = '0;
        b_nxt.gy = '0;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      b_r <= b_nxt;
    end
  end

  // stage c: products
  c_t c_r, c_nxt;
  always_comb begin
    c_nxt.cmd   = b_r.cmd;
    c_nxt.two   = b_r.two;
    c_nxt.bad   = b_r.bad;
    c_nxt.xyn   = b_r.xyn;
    c_nxt.land2 = b_r.land2;
    c_nxt.hm    = b_r.hm;
    c_nxt.mx    = b_r.mx;
    c_nxt.my    = b_r.my;
    c_nxt.nx    = b_r.nx;
    c_nxt.ny    = b_r.ny;
    c_nxt.gh    = b_r.gh;
    c_nxt.gx    = b_r.gx;
    c_nxt.gy    = b_r.gy;
    c_nxt.pxx   = 64'(b_r.mxm) * 64'(b_r.mxm);
    c_nxt.pxy   = 64'(b_r.mxm) * 64'(b_r.mym);
    c_nxt.pyy   = 64'(b_r.mym) * 64'(b_r.mym);
    c_nxt.pxn   = 48'(b_r.mx) * 48'(b_r.nx);
    c_nxt.pyn   = 48'(b_r.my) * 48'(b_r.ny);
    // gravity and height share 16 fraction bits, no rescale
    c_nxt.pgh   = 55'(b_r.hm) * 55'(gravity_r);
    c_nxt.phh   = 62'(b_r.hm) * 62'(b_r.hm);
  end
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      c_r <= c_nxt;
    end
  end

  // stage d: normal momentum, g*h*h partial products
  d_t d_r, d_nxt;
  always_comb begin
    d_nxt.cmd   = c_r.cmd;
    d_nxt.two   = c_r.two;
    d_nxt.bad   = c_r.bad;
    d_nxt.xyn   = c_r.xyn;
    d_nxt.land2 = c_r.land2;
    d_nxt.hm    = c_r.hm;
    d_nxt.mx    = c_r.mx;
    d_nxt.my    = c_r.my;
    d_nxt.nx    = c_r.nx;
    d_nxt.ny    = c_r.ny;
    d_nxt.gh    = c_r.gh;
    d_nxt.gx    = c_r.gx;
    d_nxt.gy    = c_r.gy;
    d_nxt.pxx   = c_r.pxx;
    d_nxt.pxy   = c_r.pxy;
    d_nxt.pyy   = c_r.pyy;
    d_nxt.pgh   = c_r.pgh;
    d_nxt.dot   = 49'(c_r.pxn) + 49'(c_r.pyn);
    d_nxt.hgh   = 55'(c_r.phh[61:31]) * 55'(gravity_r);
    d_nxt.hgl   = 55'(c_r.phh[30:0]) * 55'(gravity_r);
  end
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_r <= d_nxt;
    end
  end

  // stage e: half g h^2, |dot|, reflection products
  e_t          e_r, e_nxt;
  logic [85:0] hsum;
  logic [48:0] dot_neg;
  always_comb begin
    hsum    = {d_r.hgh, 31'b0} + 86'(d_r.hgl);
    dot_neg = -d_r.dot;
    e_nxt.cmd   = d_r.cmd;
    e_nxt.two   = d_r.two;
    e_nxt.bad   = d_r.bad;
    e_nxt.xyn   = d_r.xyn;
    e_nxt.land2 = d_r.land2;
    e_nxt.hm    = d_r.hm;
    e_nxt.mx    = d_r.mx;
    e_nxt.my    = d_r.my;
    e_nxt.gh    = d_r.gh;
    e_nxt.gx    = d_r.gx;
    e_nxt.gy    = d_r.gy;
    e_nxt.pxx   = d_r.pxx;
    e_nxt.pxy   = d_r.pxy;
    e_nxt.pyy   = d_r.pyy;
    e_nxt.pgh   = d_r.pgh;
    // drop value, gravity and halving fraction bits
    e_nxt.half  = (|hsum[85:64]) ? 31'h7fffffff : hsum[63:33];
    e_nxt.dotm  = d_r.dot[48] ? dot_neg[47:0] : d_r.dot[47:0];
    e_nxt.dnx   = 65'(d_r.dot) * 65'(d_r.nx);
    e_nxt.dny   = 65'(d_r.dot) * 65'(d_r.ny);
  end
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      e_r <= e_nxt;
    end
  end

  // stage f: m - 2(m.n)n at full precision
  f_t f_r, f_nxt;
  always_comb begin
    f_nxt.cmd   = e_r.cmd;
    f_nxt.two   = e_r.two;
    f_nxt.bad   = e_r.bad;
    f_nxt.xyn   = e_r.xyn;
    f_nxt.land2 = e_r.land2;
    f_nxt.hm    = e_r.hm;
    f_nxt.mx    = e_r.mx;
    f_nxt.my    = e_r.my;
    f_nxt.gh    = e_r.gh;
    f_nxt.gx    = e_r.gx;
    f_nxt.gy    = e_r.gy;
    f_nxt.pxx   = e_r.pxx;
    f_nxt.pxy   = e_r.pxy;
    f_nxt.pyy   = e_r.pyy;
    f_nxt.pgh   = e_r.pgh;
    f_nxt.dotm  = e_r.dotm;
    f_nxt.half  = e_r.half;
    f_nxt.vx    = (67'(e_r.mx) <<< (2 * swpf_pkg::NFRAC)) - (67'(e_r.dnx) <<< 1);
    f_nxt.vy    = (67'(e_r.my) <<< (2 * swpf_pkg::NFRAC)) - (67'(e_r.dny) <<< 1);
  end
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      f_r <= f_nxt;
    end
  end

  // stage g: truncate toward zero and saturate the reflected momentum
  g_t          g_r, g_nxt;
  logic [66:0] vxa, vya;
  always_comb begin
    vxa = f_r.vx[66] ? 67'(-f_r.vx) : 67'(f_r.vx);
    vya = f_r.vy[66] ? 67'(-f_r.vy) : 67'(f_r.vy);
    g_nxt.cmd  = f_r.cmd;
    g_nxt.two  = f_r.two;
    g_nxt.bad  = f_r.bad;
    g_nxt.xyn  = f_r.xyn;
    g_nxt.hm   = f_r.hm;
    g_nxt.mx   = f_r.mx;
    g_nxt.my   = f_r.my;
    g_nxt.gh   = f_r.gh;
    g_nxt.gx   = f_r.land2 ? pack_sm(f_r.vx[66], vxa[66:28]) : f_r.gx;
    g_nxt.gy   = f_r.land2 ? pack_sm(f_r.vy[66], vya[66:28]) : f_r.gy;
    g_nxt.pxx  = f_r.pxx;
    g_nxt.pxy  = f_r.pxy;
    g_nxt.pyy  = f_r.pyy;
    g_nxt.pgh  = f_r.pgh;
    g_nxt.dotm = f_r.dotm;
    g_nxt.half = f_r.half;
  end
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      g_r <= g_nxt;
    end
  end

  // divide and square-root stages, one bit each
  it_t it_init;
  it_t it_r [NITER];
  it_t it_nxt [NITER];

  always_comb begin
    it_init.cmd      = g_r.cmd;
    it_init.two      = g_r.two;
    it_init.bad      = g_r.bad;
    it_init.xyn      = g_r.xyn;
    it_init.hm       = g_r.hm;
    it_init.mx       = g_r.mx;
    it_init.my       = g_r.my;
    it_init.gh       = g_r.gh;
    it_init.gx       = g_r.gx;
    it_init.gy       = g_r.gy;
    it_init.half     = g_r.half;
    it_init.div[DXX] = div_init(g_r.pxx, g_r.hm);
    it_init.div[DXY] = div_init(g_r.pxy, g_r.hm);
    it_init.div[DYY] = div_init(g_r.pyy, g_r.hm);
    // speed dividend carries the normal-to-value rescale
    it_init.div[DSP] = div_init(64'({g_r.dotm, 2'b00}), g_r.hm);
    it_init.sq.rad   = 64'(g_r.pgh);
    it_init.sq.rem   = '0;
    it_init.sq.root  = '0;
  end

  generate
    for (genvar k = 0; k < NITER; k++) begin : g_iter
      it_t src;
      if (k == 0) begin : g_first
        assign src = it_init;
      end else begin : g_next
        assign src = it_r[k-1];
      end
      always_comb begin
        it_nxt[k]          = src;
        it_nxt[k].div[DXX] = div_step(src.div[DXX], src.hm);
        it_nxt[k].div[DXY] = div_step(src.div[DXY], src.hm);
        it_nxt[k].div[DYY] = div_step(src.div[DYY], src.hm);
        it_nxt[k].div[DSP] = div_step(src.div[DSP], src.hm);
        it_nxt[k].sq       = sq_step(src.sq);
      end
      always_ff @(posedge clk) begin
        if (adv[7+k]) begin
          it_r[k] <= it_nxt[k];
        end
      end
    end
  endgenerate

  // output stage: caps, sums and command select
  it_t         fin;
  out_t        out_r, out_nxt;
  logic [31:0] cxx, cxy, cyy;
  logic [32:0] dxx, dyy, spd;
  logic [30:0] vsp;
  swpf_pkg::val_t off;
  logic        is_flux, is_speed;

  always_comb begin
    fin      = it_r[NITER-1];
    cxx      = flux_cap(fin.div[DXX]);
    cxy      = flux_cap(fin.div[DXY]);
    cyy      = flux_cap(fin.div[DYY]);
    dxx      = 33'(cxx) + 33'(fin.half);
    dyy      = 33'(cyy) + 33'(fin.half);
    off      = pack_sm(fin.xyn, 39'(cxy));
    vsp      = (fin.div[DSP].ovf || fin.div[DSP].dq[31]) ? 31'h7fffffff
                                                          : fin.div[DSP].dq[30:0];
    spd      = 33'(vsp) + 33'(fin.sq.root);
    is_flux  = (fin.cmd == swpf_pkg::CMD_FLUX) && !fin.bad;
    is_speed = (fin.cmd == swpf_pkg::CMD_SPEED) && !fin.bad;

    out_nxt = '0;
    out_nxt.small_h = fin.bad && ((fin.cmd == swpf_pkg::CMD_FLUX) ||
                                  (fin.cmd == swpf_pkg::CMD_SPEED));
    if (is_flux) begin
      out_nxt.mass_x = fin.mx;
      out_nxt.mass_y = fin.my;
      out_nxt.xmom_x = (dxx > 33'h7fffffff) ? 32'h7fffffff : dxx[31:0];
      if (fin.two) begin
        out_nxt.xmom_y = off;
        out_nxt.ymom_x = off;
        out_nxt.ymom_y = (dyy > 33'h7fffffff) ? 32'h7fffffff : dyy[31:0];
      end
    end
    if (is_speed) begin
      out_nxt.speed = (spd > 33'h7fffffff) ? 31'h7fffffff : spd[30:0];
    end
    if (fin.cmd == swpf_pkg::CMD_GHOST) begin
      out_nxt.gh = fin.gh;
      out_nxt.gx = fin.gx;
      out_nxt.gy = fin.two ? fin.gy : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.mass_flux_x      = out_r.mass_x;
  assign out_ch.mass_flux_y      = out_r.mass_y;
  assign out_ch.xmom_flux_x      = out_r.xmom_x;
  assign out_ch.xmom_flux_y      = out_r.xmom_y;
  assign out_ch.ymom_flux_x      = out_r.ymom_x;
  assign out_ch.ymom_flux_y      = out_r.ymom_y;
  assign out_ch.wave_speed       = out_r.speed;
  assign out_ch.ghost_height     = out_r.gh;
  assign out_ch.ghost_momentum_x = out_r.gx;
  assign out_ch.ghost_momentum_y = out_r.gy;
  assign out_ch.height_too_small = out_r.small_h;

  // a flagged transaction carries nothing else
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.height_too_small |->
      out_ch.wave_speed == '0 && out_ch.xmom_flux_x == '0 && out_ch.ghost_height == '0)
    else $error("flagged result has nonzero fields");

  // results of different commands never mix
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.wave_speed != '0 |->
      out_ch.mass_flux_x == '0 && out_ch.ghost_momentum_x == '0)
    else $error("wave speed mixed with other command fields");

  // an empty output slot leaves the whole pipe open
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[LAST] |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // stalled output register holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && !out_ch.ready |=> vld_r[LAST] && $stable(out_r))
    else $error("stalled result changed");

endmodule
